/* rtl/core/spq_pkg.sv */
// spq_pkg: shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 7;
    localparam int REQ_W         = 2;

    // Request codes carried on the input tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DUMP   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // Broadcast to the whole row of cells
    typedef struct packed {
        t_cell_op op;
        t_entry   new_entry;
    } t_cell_ctl;

endpackage

/* rtl/core/spq_cell.sv */
// spq_cell: one slot of the sorted chain (entry storage, compare, shift).
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,      // slot lies below the fill count
    input  logic      i_prev_ge,    // upstream slot keeps its entry on insert
    input  t_entry    i_prev,
    input  logic      i_next_valid,
    input  t_entry    i_next,
    input  t_entry    i_head,       // slot 0, wraps around on rotate
    output t_entry    o_entry,
    output logic      o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // Signed compare; ties stay ahead of the newcomer
    assign o_ge    = i_valid && (r_entry.prio >= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INSERT: begin
                if (!o_ge) begin
                    n_entry = i_prev_ge ? i_ctl.new_entry : i_prev;
                end
            end
            OP_ROTATE: begin
                n_entry = i_next_valid ? i_next : i_head;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
// Sorted priority queue: top level, row of spq_cell slots plus request control.
// Depends on spq_pkg and spq_cell.
//
// Keeps up to DEPTH (value, priority) entries in descending priority order in a
// row of identical cells; slot 0 holds the highest priority. An insert (tuser 0)
// is placed behind every entry of greater or equal priority, so equal priorities
// leave in arrival order; every cell compares against the newcomer in parallel and
// either keeps, takes the newcomer, or takes its upstream neighbor, so an insert
// finishes in the cycle it is accepted and gives one status result. An insert
// into a full queue changes nothing and reports overflow. A dump (tuser 1) streams
// one entry per cycle from slot 0, pausing while the receiver stalls, as the
// occupied cells rotate one place toward slot 0; after entry_count steps the row
// is back in order. No new request is taken while a dump of a non-empty queue
// streams; a dump of an empty queue gives one result, flagged empty. Clear
// (tuser 2) zeroes the fill count and returns one result; code 3 is taken and
// dropped. The output sits in a single register; a new request is taken while
// that register is empty or being drained in the same cycle.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF     // 1 .. 64
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // [31:0] item_value, [63:32] item_priority
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] req_type
    // result side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // [31:0] out_value, [63:32] out_priority,
                                         // [70:64] entry_count, [71] zero
    output logic        o_m_axis_tlast,  // is_last
    output logic [1:0]  o_m_axis_tuser   // [0] is_empty, [1] overflow
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;     // entries held
    logic [CNT_W-1:0] r_remain;    // entries still to stream in a dump

    // output register
    logic               r_out_valid;
    t_entry             r_out_entry;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_last;
    logic               r_out_empty;
    logic               r_out_ovf;

    t_cell_ctl          ctl;
    t_entry             cell_entry [DEPTH];
    logic [DEPTH-1:0]   cell_ge;
    logic [DEPTH-1:0]   cell_valid;

    logic      slot_free;
    logic      req_acc;
    t_req_type req;
    logic      full;
    logic      out_load;   // a result enters the output register this cycle

    assign slot_free       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && slot_free;
    assign req_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign req             = t_req_type'(i_s_axis_tuser);
    assign full            = (r_count == CNT_W'(DEPTH));
    assign out_load        = (req_acc && req != REQ_NONE &&
                              !(req == REQ_DUMP && r_count != '0)) ||
                             (r_state == ST_DUMP && slot_free);

    // cell control: insert on an accepted insert with room, rotate while streaming
    always_comb begin
        ctl.new_entry.value = i_s_axis_tdata[31:0];
        ctl.new_entry.prio  = i_s_axis_tdata[63:32];
        ctl.op              = OP_HOLD;
        if (req_acc && req == REQ_INSERT && !full) begin
            ctl.op = OP_INSERT;
        end else if (r_state == ST_DUMP && slot_free) begin
            ctl.op = OP_ROTATE;
        end
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   prev_ge;
        t_entry prev_e;
        logic   next_v;
        t_entry next_e;

        assign cell_valid[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign prev_ge = 1'b1;
            assign prev_e  = cell_entry[0];
        end else begin : g_mid
            assign prev_ge = cell_ge[g-1];
            assign prev_e  = cell_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_v = 1'b0;
            assign next_e = cell_entry[0];
        end else begin : g_inner
            assign next_v = cell_valid[g+1];
            assign next_e = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_valid      (cell_valid[g]),
            .i_prev_ge    (prev_ge),
            .i_prev       (prev_e),
            .i_next_valid (next_v),
            .i_next       (next_e),
            .i_head       (cell_entry[0]),
            .o_entry      (cell_entry[g]),
            .o_ge         (cell_ge[g])
        );
    end

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (req_acc) begin
                        case (req)
                            REQ_INSERT: begin
                                r_out_entry <= '0;
                                r_out_last  <= 1'b1;
                                r_out_empty <= 1'b0;
                                r_out_ovf   <= full;
                                r_out_count <= full ? r_count : r_count + 1'b1;
                                if (!full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            REQ_DUMP: begin
                                if (r_count == '0) begin
                                    r_out_entry <= '0;
                                    r_out_last  <= 1'b1;
                                    r_out_empty <= 1'b1;
                                    r_out_ovf   <= 1'b0;
                                    r_out_count <= '0;
                                end else begin
                                    r_remain <= r_count;
                                    r_state  <= ST_DUMP;
                                end
                            end
                            REQ_CLEAR: begin
                                r_count     <= '0;
                                r_out_entry <= '0;
                                r_out_last  <= 1'b1;
                                r_out_empty <= 1'b0;
                                r_out_ovf   <= 1'b0;
                                r_out_count <= '0;
                            end
                            default: begin
                                // unused code: taken, no result
                            end
                        endcase
                    end
                end
                ST_DUMP: begin
                    if (slot_free) begin
                        r_out_entry <= cell_entry[0];
                        r_out_last  <= (r_remain == CNT_W'(1));
                        r_out_empty <= 1'b0;
                        r_out_ovf   <= 1'b0;
                        r_out_count <= r_count;
                        r_remain    <= r_remain - 1'b1;
                        if (r_remain == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid       = r_out_valid;
    assign o_m_axis_tdata[31:0]  = r_out_entry.value;
    assign o_m_axis_tdata[63:32] = r_out_entry.prio;
    assign o_m_axis_tdata[70:64] = ENTRY_COUNT_W'(r_out_count);
    assign o_m_axis_tdata[71]    = 1'b0;
    assign o_m_axis_tlast        = r_out_last;
    assign o_m_axis_tuser        = {r_out_ovf, r_out_empty};

endmodule

/* rtl/core/spq_checker.sv */
// spq_checker: port-level assertions for sorted_priority_queue_top, and its bind.
// Depends on spq_pkg and sorted_priority_queue_top.
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // no request taken in the middle of a dump
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("request taken mid-dump");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[70:64] <= ENTRY_COUNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            o_m_axis_tdata[70:64] == ENTRY_COUNT_W'(DEPTH) && o_m_axis_tlast)
        else $error("overflow without full queue");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[70:64] == '0 && o_m_axis_tlast && !o_m_axis_tuser[1])
        else $error("empty flag with entries held");

endmodule

bind sorted_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* tb/spq_checker.sv */
// spq_scoreboard: watches the request and result streams of the sorted priority queue,
// keeps its own sorted copy of the stored entries and compares every result.
// Depends on spq_pkg for the request codes and the default depth.
module spq_scoreboard
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [63:0] i_req_tdata,   // [31:0] item_value, [63:32] item_priority
    input  logic [1:0]  i_req_tuser,   // [1:0] req_type
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    input  logic [71:0] i_res_tdata,   // [31:0] out_value, [63:32] out_priority,
                                       // [70:64] entry_count, [71] zero
    input  logic        i_res_tlast,   // is_last
    input  logic [1:0]  i_res_tuser,   // [0] is_empty, [1] overflow
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] val;
        logic [31:0] prio;
        logic        last;
        logic        empty;
        logic        ovf;
        logic [6:0]  count;
    } t_spq_result;

    t_spq_result awaited_results[$];
    logic [31:0] shadow_val  [DEPTH];
    logic [31:0] shadow_prio [DEPTH];
    int          shadow_count = 0;
    int          fails        = 0;
    int          waiting      = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    task automatic queue_result(logic [31:0] v, logic [31:0] p, logic last,
                                logic empty, logic ovf);
        t_spq_result r;
        r.val   = v;
        r.prio  = p;
        r.last  = last;
        r.empty = empty;
        r.ovf   = ovf;
        r.count = shadow_count[6:0];
        awaited_results.push_back(r);
    endtask

    // Models one request; inserts go behind entries of greater or equal priority
    task automatic apply_request(logic [1:0] kind, logic [31:0] v, logic [31:0] p);
        int pos;
        pos = 0;
        case (kind)
            REQ_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    queue_result('0, '0, 1'b1, 1'b0, 1'b1);
                end else begin
                    while (pos < shadow_count && $signed(shadow_prio[pos]) >= $signed(p))
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_val[i]  = shadow_val[i-1];
                        shadow_prio[i] = shadow_prio[i-1];
                    end
                    shadow_val[pos]  = v;
                    shadow_prio[pos] = p;
                    shadow_count++;
                    queue_result('0, '0, 1'b1, 1'b0, 1'b0);
                end
            end
            REQ_DUMP: begin
                if (shadow_count == 0) begin
                    queue_result('0, '0, 1'b1, 1'b1, 1'b0);
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        queue_result(shadow_val[i], shadow_prio[i],
                                     (i == shadow_count - 1), 1'b0, 1'b0);
                end
            end
            REQ_CLEAR: begin
                shadow_count = 0;
                queue_result('0, '0, 1'b1, 1'b0, 1'b0);
            end
            default: ;  // unused code: dropped, no result
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_spq_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            // output is registered, so a result never belongs to this edge's request
            if (i_res_tvalid && i_res_tready) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %0h last %0b user %0b",
                             $time, i_res_tdata, i_res_tlast, i_res_tuser);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_value",    want.val,          i_res_tdata[31:0]);
                    check_field("out_priority", want.prio,         i_res_tdata[63:32]);
                    check_field("entry_count",  {25'd0, want.count}, {25'd0, i_res_tdata[70:64]});
                    check_field("is_last",      {31'd0, want.last},  {31'd0, i_res_tlast});
                    check_field("is_empty",     {31'd0, want.empty}, {31'd0, i_res_tuser[0]});
                    check_field("overflow",     {31'd0, want.ovf},   {31'd0, i_res_tuser[1]});
                end
            end
            if (i_req_tvalid && i_req_tready)
                apply_request(i_req_tuser, i_req_tdata[31:0], i_req_tdata[63:32]);
        end
        waiting = awaited_results.size();
    end

endmodule

/* tb/tb.sv */
// tb: top of the sorted priority queue testbench; makes requests, drives the
// result-side ready and gives the verdict. Depends on spq_pkg, spq_scoreboard and
// sorted_priority_queue_top.
module tb
    import spq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int RAND_ITEMS = 330;
    // Worst case is roughly every request a full dump with the receiver stalling;
    // this is many times that.
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // request side, all known from time zero
    logic        req_tvalid = 1'b0;
    logic        req_tready;
    logic [63:0] req_tdata  = '0;   // [31:0] item_value, [63:32] item_priority
    logic [1:0]  req_tuser  = REQ_NONE;  // [1:0] req_type

    // result side
    logic        res_tvalid;
    logic        res_tready = 1'b0;
    logic [71:0] res_tdata;         // [31:0] out_value, [63:32] out_priority,
                                    // [70:64] entry_count, [71] zero
    logic        res_tlast;         // is_last
    logic [1:0]  res_tuser;         // [0] is_empty, [1] overflow

    int fail_count;
    int pending;
    int cycles        = 0;
    int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int recv_stall_pct = 0;  // chance in a hundred that the receiver holds off

    always #2 i_clk = ~i_clk;

    sorted_priority_queue_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(req_tvalid),
        .o_s_axis_tready(req_tready),
        .i_s_axis_tdata (req_tdata),
        .i_s_axis_tuser (req_tuser),
        .o_m_axis_tvalid(res_tvalid),
        .i_m_axis_tready(res_tready),
        .o_m_axis_tdata (res_tdata),
        .o_m_axis_tlast (res_tlast),
        .o_m_axis_tuser (res_tuser)
    );

    spq_scoreboard #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_tvalid(req_tvalid),
        .i_req_tready(req_tready),
        .i_req_tdata (req_tdata),
        .i_req_tuser (req_tuser),
        .i_res_tvalid(res_tvalid),
        .i_res_tready(res_tready),
        .i_res_tdata (res_tdata),
        .i_res_tlast (res_tlast),
        .i_res_tuser (res_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        res_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // One request: optional idle cycles, then hold valid until taken.
    // Entered right after an edge, so each edge sees one assignment to valid.
    task automatic send_request(t_req_type kind, logic [31:0] val, logic [31:0] prio);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        req_tvalid <= 1'b1;
        req_tuser  <= kind;
        req_tdata  <= {prio, val};
        do @(posedge i_clk); while (!req_tready);
    endtask

    // Random value with the extremes mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Priorities lean on a narrow band so ties are frequent
    function automatic logic [31:0] pick_prio();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 4) - 2;
            4:          return 32'h7fff_ffff;
            5:          return 32'h8000_0000;
            default:    return $urandom();
        endcase
    endfunction

    initial begin
        int r;
        t_req_type kind;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: empty dump, dropped code, extremes, ties, full store ---
        send_request(REQ_DUMP,   32'h1234_5678, 32'h0);
        send_request(REQ_NONE,   32'hdead_beef, 32'h7fff_ffff);
        send_request(REQ_INSERT, 32'h7fff_ffff, 32'h8000_0000);   // lowest priority
        send_request(REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff);   // highest priority
        send_request(REQ_INSERT, 32'hffff_ffff, 32'h7fff_ffff);   // tie, goes behind
        send_request(REQ_INSERT, 32'h0000_0001, 32'h0);
        send_request(REQ_INSERT, 32'h0000_0002, 32'hffff_ffff);
        send_request(REQ_DUMP,   32'h0, 32'h0);
        // fill to the brim with a handful of tied priorities
        for (int i = 0; i < DEPTH - 5; i++)
            send_request(REQ_INSERT, 32'h100 + i, $urandom_range(0, 2) - 1);
        send_request(REQ_INSERT, 32'haaaa_5555, 32'h5555_aaaa);   // refused, store full
        send_request(REQ_DUMP,   32'h0, 32'h0);
        send_request(REQ_CLEAR,  32'hffff_ffff, 32'hffff_ffff);
        send_request(REQ_DUMP,   32'h0, 32'h0);

        // --- random: four back-pressure phases ---
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < RAND_ITEMS / 4; n++) begin
                // mostly inserts so the store fills and overflows between clears
                r = $urandom_range(0, 99);
                if (r < 72)      kind = REQ_INSERT;
                else if (r < 87) kind = REQ_DUMP;
                else if (r < 92) kind = REQ_CLEAR;
                else             kind = REQ_NONE;
                send_request(kind, pick_value(), pick_prio());
            end
        end
        req_tvalid <= 1'b0;

        // drain, then give a late or extra result time to show up
        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH + 16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
